### rtl/tcw_pkg.sv
// Package for the text console writer: geometry, field widths, character
// codes, sequencer states and the structs passed between modules.
// No dependencies.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// Field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;

	localparam logic [ADDR_W-1:0] COLUMNS_A  = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] CELLS_A    = ADDR_W'(CELLS);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_CELLS = ADDR_W'(CELLS - COLUMNS);

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

	// Item functions
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Control characters
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam int                TAB_STEP   = 4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cursor_t;

	// Outcome of a put at the current cursor
	typedef struct packed {
		cursor_t           nxt;
		logic              write;
		logic              scroll;
		logic [ADDR_W-1:0] index;
	} step_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} result_t;

endpackage

### rtl/tcw_req_if.sv
// Request channel of the text console writer: valid/ready plus item fields.
// Depends on tcw_pkg.
interface tcw_req_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [CHAR_W-1:0] char_code;
	logic [CHAR_W-1:0] color;
	logic [ADDR_W-1:0] cell_address;

	modport source (output valid, func, char_code, color, cell_address, input ready);
	modport sink   (input valid, func, char_code, color, cell_address, output ready);
endinterface

### rtl/tcw_rsp_if.sv
// Response channel of the text console writer: valid/ready plus result fields.
// Depends on tcw_pkg.
interface tcw_rsp_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_data;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;
	logic [ADDR_W-1:0] cursor_position;
	logic              scrolled;

	modport source (output valid, cell_data, cursor_column, cursor_row, cursor_position,
		scrolled, input ready);
	modport sink   (input valid, cell_data, cursor_column, cursor_row, cursor_position,
		scrolled, output ready);
endinterface

### rtl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/tcw_cursor.sv
// Cursor register and put decode: next cursor, cell write and scroll decision.
// Depends on tcw_pkg.
module tcw_cursor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic                       commit,
	output tcw_pkg::cursor_t           cur,
	output tcw_pkg::step_t             step
);
	import tcw_pkg::*;

	cursor_t          cur_q;
	logic [COL_W:0]   col_t;
	logic [ROW_W:0]   row_t;

	assign cur = cur_q;

	always_comb begin
		col_t       = {1'b0, cur_q.col};
		row_t       = {1'b0, cur_q.row};
		step.write  = 1'b0;
		step.scroll = 1'b0;
		unique case (char_code)
			CH_NEWLINE: begin
				col_t = '0;
				row_t = row_t + 1'b1;
			end
			CH_RETURN: begin
				col_t = '0;
			end
			CH_TAB: begin
				col_t = col_t + (COL_W+1)'(TAB_STEP);
			end
			CH_NUL: begin
			end
			default: begin
				step.write = 1'b1;
				col_t      = col_t + 1'b1;
			end
		endcase
		// wrap past the last column
		if (col_t >= (COL_W+1)'(COLUMNS)) begin
			col_t = '0;
			row_t = row_t + 1'b1;
		end
		// past the last row: scroll and park on the bottom row
		if (row_t >= (ROW_W+1)'(ROWS)) begin
			step.scroll = 1'b1;
			row_t       = (ROW_W+1)'(ROWS - 1);
			col_t       = '0;
		end
		step.nxt.col = col_t[COL_W-1:0];
		step.nxt.row = row_t[ROW_W-1:0];
		step.index   = ADDR_W'(cur_q.row) * COLUMNS_A + ADDR_W'(cur_q.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (commit) begin
			cur_q <= step.nxt;
		end
	end
endmodule

### rtl/tcw_seq.sv
// Sequencer around the cell store: reset sweep, put, read, scroll copy and
// bottom-row fill. Depends on tcw_pkg and tcw_ram.
module tcw_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_func,
	input  logic [tcw_pkg::CHAR_W-1:0] in_char_code,
	input  logic [tcw_pkg::CHAR_W-1:0] in_color,
	input  logic [tcw_pkg::ADDR_W-1:0] in_cell_address,
	output logic [tcw_pkg::CHAR_W-1:0] char_code,
	output logic                       commit,
	input  tcw_pkg::step_t             step,
	output logic                       res_valid,
	input  logic                       res_ready,
	output tcw_pkg::result_t           res
);
	import tcw_pkg::*;

	seq_state_t        state_q, state_d;
	logic [ADDR_W-1:0] cnt_q;
	logic              func_q;
	logic [CHAR_W-1:0] char_q;
	logic [CHAR_W-1:0] color_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CELL_W-1:0] data_q;
	logic              scrolled_q;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] copy_a_s1;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CELL_W-1:0] wdata, rdata;
	logic              copy_rd;

	tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign char_code     = char_q;
	assign copy_rd       = (cnt_q < COPY_CELLS);
	assign res.cell_data = data_q;
	assign res.scrolled  = scrolled_q;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		commit    = 1'b0;
		we        = 1'b0;
		waddr     = cnt_q;
		wdata     = BLANK_CELL;
		re        = 1'b0;
		raddr     = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (cnt_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (func_q == FUNC_READ) begin
					re      = (addr_q < CELLS_A);
					state_d = (addr_q < CELLS_A) ? ST_RDATA : ST_DONE;
				end else begin
					commit  = 1'b1;
					we      = step.write;
					waddr   = step.index;
					wdata   = {color_q, char_q};
					state_d = step.scroll ? ST_COPY : ST_DONE;
				end
			end
			ST_RDATA: begin
				state_d = ST_DONE;
			end
			ST_COPY: begin
				// write the row below one row up, one beat behind the read
				we    = copy_v_s1;
				waddr = copy_a_s1;
				wdata = rdata;
				re    = copy_rd;
				raddr = cnt_q + COLUMNS_A;
				if (!copy_rd) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				we = 1'b1;
				if (cnt_q == LAST_CELL) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			copy_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			copy_v_s1 <= (state_q == ST_COPY) && copy_rd;
			priority case (state_q)
				ST_CLEAR: cnt_q <= (cnt_q == LAST_CELL) ? '0 : cnt_q + 1'b1;
				ST_EXEC:  cnt_q <= '0;
				ST_COPY:  cnt_q <= copy_rd ? cnt_q + 1'b1 : cnt_q;
				ST_FILL:  cnt_q <= cnt_q + 1'b1;
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		copy_a_s1 <= cnt_q;
		if (state_q == ST_IDLE && in_valid) begin
			func_q  <= in_func;
			char_q  <= in_char_code;
			color_q <= in_color;
			addr_q  <= in_cell_address;
		end
		if (state_q == ST_EXEC) begin
			if (func_q == FUNC_READ) begin
				data_q     <= '0;
				scrolled_q <= 1'b0;
			end else begin
				data_q     <= step.write ? {color_q, char_q} : '0;
				scrolled_q <= step.scroll;
			end
		end else if (state_q == ST_RDATA) begin
			data_q <= rdata;
		end
	end
endmodule

### rtl/text_console_writer.sv
// Text console writer: 80x25 cell store with cursor, put and read items.
//
// Use: each beat on req is one item. func selects a put of char_code with
// attribute color at the cursor, or a read of the cell at cell_address.
// Newline, carriage return, tab and NUL move the cursor only; any other
// byte writes (color << 8) | char_code and advances the cursor. Each item
// yields exactly one beat on rsp carrying the cell word (zero for control
// characters and out-of-range reads), the cursor after the item, its linear
// position and a scroll flag.
// Flow: one item at a time. A put goes through ST_EXEC and ST_DONE
// before it loads the response register, an in-range read also through
// ST_RDATA; an out-of-range read takes the same path as a put.
// A put that runs off the bottom row also copies rows up through the single
// read and write ports of the cell RAM, one cell per cycle, then blanks the
// bottom row in ST_FILL before the response is offered.
// Reset: arst_n clears the cursor and starts a sweep that writes 0x0720 to
// every cell, one per cycle; req.ready stays low until done.
// Stall: rsp has an output register, so the next item is taken while a
// result waits; the engine holds its finished result until that register
// frees up. Depends on tcw_pkg, the two channel interfaces, tcw_seq and
// tcw_cursor.
module text_console_writer (
	input logic      clk,
	input logic      arst_n,
	tcw_req_if.sink  req,
	tcw_rsp_if.source rsp
);
	import tcw_pkg::*;

	cursor_t           cur;
	step_t             step;
	logic              commit;
	logic [CHAR_W-1:0] char_code;
	logic              res_valid;
	logic              res_ready;
	result_t           res;

	logic              rsp_valid_q;
	result_t           res_q;
	cursor_t           cur_q;
	logic [ADDR_W-1:0] pos_q;

	tcw_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (req.valid),
		.in_ready        (req.ready),
		.in_func         (req.func),
		.in_char_code    (req.char_code),
		.in_color        (req.color),
		.in_cell_address (req.cell_address),
		.char_code       (char_code),
		.commit          (commit),
		.step            (step),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res)
	);

	tcw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.commit    (commit),
		.cur       (cur),
		.step      (step)
	);

	// Output register: take a new result when empty or being drained
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	// The cursor register already holds the post-item cursor by the time the
	// sequencer offers its result, so step.index is the new linear position.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
			cur_q <= cur;
			pos_q <= step.index;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.cell_data       = res_q.cell_data;
	assign rsp.scrolled        = res_q.scrolled;
	assign rsp.cursor_column   = cur_q.col;
	assign rsp.cursor_row      = cur_q.row;
	assign rsp.cursor_position = pos_q;
endmodule

### rtl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [tcw_pkg::CELL_W-1:0] rsp_cell_data,
	input logic [tcw_pkg::COL_W-1:0]  rsp_cursor_column,
	input logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row,
	input logic [tcw_pkg::ADDR_W-1:0] rsp_cursor_position,
	input logic                       rsp_scrolled
);
	import tcw_pkg::*;

	// Hold a stalled response beat
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_data)
		&& $stable(rsp_cursor_position))
		else $error("stalled response beat changed");

	// One item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while an item is in work");

	// Position agrees with column and row
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_cursor_position ==
		ADDR_W'(rsp_cursor_row) * COLUMNS_A + ADDR_W'(rsp_cursor_column))
		else $error("cursor position does not match column and row");

	// Cursor stays on screen
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_cursor_column < COL_W'(COLUMNS))
		&& (rsp_cursor_row < ROW_W'(ROWS)))
		else $error("cursor off screen");

	// A scroll parks the cursor at the start of the bottom row
	a_scroll_park: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_scrolled |-> rsp_cursor_column == '0
		&& rsp_cursor_row == ROW_W'(ROWS - 1))
		else $error("scroll left cursor away from bottom row start");
endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_cell_data       (rsp.cell_data),
	.rsp_cursor_column   (rsp.cursor_column),
	.rsp_cursor_row      (rsp.cursor_row),
	.rsp_cursor_position (rsp.cursor_position),
	.rsp_scrolled        (rsp.scrolled)
);

### sim/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: directed table, then random text traffic.
// Predicts beats from a screen and cursor model; typed directed rows take the table's view.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and the RTL top level.
module tb_text_console_writer;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	// Worst case is every item scrolling through a full copy and fill of the store,
	// plus the sender's and receiver's gaps, on up to roughly 850 items after the
	// clearing sweep. Allow about three times that.
	localparam int CYCLE_LIMIT   = 6_000_000;
	localparam int RANDOM_ITEMS  = 650;
	localparam int TRAIL_CYCLES  = 32;
	localparam int IDLE_PERCENT  = 18;

	// What one response beat should carry
	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [ADDR_W-1:0] pos;
		logic              scrolled;
	} console_view_t;

	// One row of stimulus; view only counts where typed is set
	typedef struct packed {
		logic              func;
		logic [CHAR_W-1:0] char_code;
		logic [CHAR_W-1:0] color;
		logic [ADDR_W-1:0] cell_address;
		logic              typed;
		console_view_t     view;
	} stim_row_t;

	// Directed rows. The cursor walks from home; the typed rows are the ones whose
	// outcome is plain from reset state, the extremes and the control characters.
	localparam int N_DIRECTED = 23;
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{FUNC_READ, CH_NUL,     8'h00, 11'd0,    1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0,  1'b0}},
		'{FUNC_READ, CH_NUL,     8'h00, 11'd1999, 1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0,  1'b0}},
		'{FUNC_READ, 8'hFF,      8'hFF, 11'd2047, 1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0,  1'b0}},
		'{FUNC_READ, CH_NUL,     8'h00, 11'd2000, 1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0,  1'b0}},
		'{FUNC_PUT,  8'h41,      8'h1F, 11'd0,    1'b1, '{16'h1F41,   7'd1, 5'd0, 11'd1,  1'b0}},
		'{FUNC_PUT,  8'hFF,      8'hFF, 11'd2047, 1'b1, '{16'hFFFF,   7'd2, 5'd0, 11'd2,  1'b0}},
		'{FUNC_PUT,  8'h80,      8'h00, 11'd0,    1'b1, '{16'h0080,   7'd3, 5'd0, 11'd3,  1'b0}},
		'{FUNC_PUT,  CH_NUL,     8'hAB, 11'd5,    1'b1, '{16'h0000,   7'd3, 5'd0, 11'd3,  1'b0}},
		'{FUNC_PUT,  CH_TAB,     8'h00, 11'd0,    1'b1, '{16'h0000,   7'd7, 5'd0, 11'd7,  1'b0}},
		'{FUNC_PUT,  CH_RETURN,  8'h00, 11'd0,    1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0,  1'b0}},
		'{FUNC_PUT,  CH_NEWLINE, 8'h00, 11'd0,    1'b1, '{16'h0000,   7'd0, 5'd1, 11'd80, 1'b0}},
		// a read ignores char_code, even a newline
		'{FUNC_READ, CH_NEWLINE, 8'h5A, 11'd0,    1'b0, '0},
		'{FUNC_READ, CH_TAB,     8'h00, 11'd1,    1'b0, '0},
		'{FUNC_READ, CH_NUL,     8'h00, 11'd2,    1'b0, '0},
		'{FUNC_PUT,  8'h01,      8'h80, 11'd0,    1'b0, '0},
		'{FUNC_PUT,  8'h7F,      8'h55, 11'd0,    1'b0, '0},
		'{FUNC_PUT,  8'h08,      8'hAA, 11'd0,    1'b0, '0},
		'{FUNC_PUT,  8'h0B,      8'h0F, 11'd0,    1'b0, '0},
		'{FUNC_READ, CH_NUL,     8'h00, 11'h555,  1'b0, '0},
		'{FUNC_READ, CH_NUL,     8'h00, 11'h2AA,  1'b0, '0},
		'{FUNC_READ, CH_NUL,     8'h00, 11'd81,   1'b0, '0},
		'{FUNC_PUT,  CH_NEWLINE, 8'hF0, 11'd0,    1'b0, '0},
		'{FUNC_PUT,  CH_TAB,     8'h00, 11'd0,    1'b0, '0}
	};

	logic clk;
	logic arst_n;

	tcw_req_if req_ch ();
	tcw_rsp_if rsp_ch ();

	text_console_writer dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	// Screen and cursor as the predictor sees them
	logic [CELL_W-1:0] screen_model [CELLS];
	int                pred_col;
	int                pred_row;

	console_view_t expected_views [$];
	int            mismatch_count;
	int            items_sent;
	int            cycle_count;
	bit            gaps_on;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Work out the beat that an accepted item must produce, and advance the model.
	function automatic console_view_t predict_console(input logic func,
		input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] attr,
		input logic [ADDR_W-1:0] addr);
		console_view_t v;
		int            col;
		int            row;
		int            k;
		v   = '0;
		col = pred_col;
		row = pred_row;
		if (func == FUNC_READ) begin
			// out-of-range reads give zero and never touch the cursor
			if (addr < CELLS)
				v.cell_data = screen_model[addr];
		end else begin
			if (ch == CH_NEWLINE) begin
				col = 0;
				row++;
			end else if (ch == CH_RETURN) begin
				col = 0;
			end else if (ch == CH_TAB) begin
				col += TAB_STEP;
			end else if (ch != CH_NUL) begin
				v.cell_data = {attr, ch};
				screen_model[row * COLUMNS + col] = {attr, ch};
				col++;
			end
			// wrap past the last column, whether by a character or a tab
			if (col >= COLUMNS) begin
				col = 0;
				row++;
			end
			// off the bottom: shift every row up and blank the last one
			if (row >= ROWS) begin
				for (k = 0; k < CELLS - COLUMNS; k++)
					screen_model[k] = screen_model[k + COLUMNS];
				for (k = CELLS - COLUMNS; k < CELLS; k++)
					screen_model[k] = BLANK_CELL;
				row        = ROWS - 1;
				col        = 0;
				v.scrolled = 1'b1;
			end
			pred_col = col;
			pred_row = row;
		end
		v.col = COL_W'(col);
		v.row = ROW_W'(row);
		v.pos = ADDR_W'(row * COLUMNS + col);
		return v;
	endfunction

	function automatic stim_row_t put_row(input logic [CHAR_W-1:0] ch,
		input logic [CHAR_W-1:0] attr);
		stim_row_t it;
		it           = '0;
		it.func      = FUNC_PUT;
		it.char_code = ch;
		it.color     = attr;
		// junk in the unused address field
		it.cell_address = ADDR_W'($urandom_range(2047));
		return it;
	endfunction

	// Mostly in range, some near the cursor's row, some past the end of the store
	function automatic stim_row_t read_row();
		stim_row_t it;
		int        pick;
		it        = '0;
		it.func   = FUNC_READ;
		it.char_code = CHAR_W'($urandom_range(255));
		it.color  = CHAR_W'($urandom_range(255));
		pick      = $urandom_range(99);
		if (pick < 55)
			it.cell_address = ADDR_W'($urandom_range(CELLS - 1));
		else if (pick < 80)
			it.cell_address = ADDR_W'(pred_row * COLUMNS + $urandom_range(COLUMNS - 1));
		else if (pick < 90)
			it.cell_address = ADDR_W'($urandom_range(2047, CELLS));
		else
			it.cell_address = ADDR_W'($urandom_range(2047));
		return it;
	endfunction

	// Present one item at the falling edge, hold it until a rising edge takes the
	// beat, then record what it must produce.
	task automatic offer_item(input stim_row_t it);
		console_view_t predicted;
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.func         <= it.func;
		req_ch.char_code    <= it.char_code;
		req_ch.color        <= it.color;
		req_ch.cell_address <= it.cell_address;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predicted = predict_console(it.func, it.char_code, it.color, it.cell_address);
		expected_views.push_back(it.typed ? it.view : predicted);
		// a NUL put leaves the block as it was, so it does not count as traffic
		if (!(it.func == FUNC_PUT && it.char_code == CH_NUL))
			items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold off until every outstanding beat has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// A line of text, sometimes long enough to wrap, with the odd read-back,
	// ended by a newline, a return plus newline, or nothing.
	task automatic send_line();
		int              len;
		int              i;
		logic [CHAR_W-1:0] ch;
		len = ($urandom_range(7) == 0) ? $urandom_range(170, 81) : $urandom_range(60, 0);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				ch = CHAR_W'($urandom_range(255, 1));
			else
				ch = CHAR_W'($urandom_range(126, 32));
			offer_item(put_row(ch, CHAR_W'($urandom_range(255))));
			if ($urandom_range(11) == 0)
				offer_item(read_row());
		end
		case ($urandom_range(3))
			1: begin
				offer_item(put_row(CH_RETURN, CHAR_W'($urandom_range(255))));
				offer_item(put_row(CH_NEWLINE, CHAR_W'($urandom_range(255))));
			end
			2: ;
			default: offer_item(put_row(CH_NEWLINE, CHAR_W'($urandom_range(255))));
		endcase
	endtask

	// A few characters to shift the column off the tab grid, then a run of tabs
	// that wraps either exactly at the last column or past it.
	task automatic send_tabs();
		int n;
		int i;
		n = $urandom_range(3);
		for (i = 0; i < n; i++)
			offer_item(put_row(CHAR_W'($urandom_range(126, 32)), CHAR_W'($urandom_range(255))));
		n = $urandom_range(25, 1);
		for (i = 0; i < n; i++)
			offer_item(put_row(CH_TAB, CHAR_W'($urandom_range(255))));
	endtask

	// Any field value at all, NUL and control characters included
	task automatic send_noise();
		stim_row_t it;
		it              = '0;
		it.func         = 1'($urandom_range(1));
		it.char_code    = CHAR_W'($urandom_range(255));
		it.color        = CHAR_W'($urandom_range(255));
		it.cell_address = ADDR_W'($urandom_range(2047));
		offer_item(it);
	endtask

	// Compare a response beat with the oldest expectation, field by field
	task automatic check_beat();
		console_view_t want;
		if (expected_views.size() == 0) begin
			$error("response beat with no item outstanding: cell_data %h", rsp_ch.cell_data);
			mismatch_count++;
		end else begin
			want = expected_views.pop_front();
			if (rsp_ch.cell_data !== want.cell_data) begin
				$error("cell_data: expected %h, got %h", want.cell_data, rsp_ch.cell_data);
				mismatch_count++;
			end
			if (rsp_ch.cursor_column !== want.col) begin
				$error("cursor_column: expected %0d, got %0d", want.col, rsp_ch.cursor_column);
				mismatch_count++;
			end
			if (rsp_ch.cursor_row !== want.row) begin
				$error("cursor_row: expected %0d, got %0d", want.row, rsp_ch.cursor_row);
				mismatch_count++;
			end
			if (rsp_ch.cursor_position !== want.pos) begin
				$error("cursor_position: expected %0d, got %0d", want.pos,
					rsp_ch.cursor_position);
				mismatch_count++;
			end
			if (rsp_ch.scrolled !== want.scrolled) begin
				$error("scrolled: expected %0b, got %0b", want.scrolled, rsp_ch.scrolled);
				mismatch_count++;
			end
		end
	endtask

	// Sample response beats at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			check_beat();
	end

	// Receiver: stall at random, except through the quiet stretch
	always @(negedge clk) begin
		rsp_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int  pick;
		bit  mid_drain_done;
		int  i;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.func         = FUNC_PUT;
		req_ch.char_code    = '0;
		req_ch.color        = '0;
		req_ch.cell_address = '0;
		rsp_ch.ready        = 1'b0;
		gaps_on             = 1'b1;
		mismatch_count      = 0;
		items_sent          = 0;
		cycle_count         = 0;
		mid_drain_done      = 1'b0;
		pred_col            = 0;
		pred_row            = 0;
		for (i = 0; i < CELLS; i++)
			screen_model[i] = BLANK_CELL;

		// Hold reset low, then release it away from the rising edge.
		// The block then sweeps its store and keeps ready low meanwhile.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < N_DIRECTED; i++)
			offer_item(DIRECTED_ROWS[i]);
		drain_results();
		items_sent = 0;

		while (items_sent < RANDOM_ITEMS) begin
			// a stretch in the middle runs with no gaps on either side
			gaps_on = !(items_sent >= 420 && items_sent < 540);
			if (!mid_drain_done && items_sent >= RANDOM_ITEMS / 2) begin
				mid_drain_done = 1'b1;
				drain_results();
			end
			pick = $urandom_range(99);
			if (pick < 68)
				send_line();
			else if (pick < 78)
				send_tabs();
			else if (pick < 88)
				offer_item(read_row());
			else
				send_noise();
		end

		// Stop sending, let every beat come back, then a short settling window
		gaps_on = 1'b1;
		req_ch.valid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (TRAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
